### rtl/sll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_pkg
// Shared widths, command codes and structs of the linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = 8;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = 9;
	localparam int CMD_W   = 4;
	localparam int POS_W   = 9;

	localparam logic [CMD_W-1:0] CMD_INIT   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_NEW    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_EMPTY  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_LENGTH = 4'd4;
	localparam logic [CMD_W-1:0] CMD_GET    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_PRIOR  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_NEXT   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_INSERT = 4'd9;
	localparam logic [CMD_W-1:0] CMD_DELETE = 4'd10;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} sll_lreq_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} sll_dreq_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0]  index;
		logic [7:0]        count;
	} sll_res_t;

endpackage

### rtl/sll_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/sll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_ctrl
// Command sequencer: walks, reads and rewrites the link and data memories.
// ----------------------------------------------------------------------------
module sll_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [sll_pkg::CMD_W-1:0] cmd,
	input  logic [sll_pkg::IDX_W-1:0] list_head,
	input  logic [sll_pkg::POS_W-1:0] position,
	input  logic [sll_pkg::DATA_W-1:0] value,
	output logic                      res_valid,
	output sll_pkg::sll_res_t         res,
	input  logic                      res_take,
	output sll_pkg::sll_lreq_t        lreq,
	input  logic [sll_pkg::IDX_W-1:0] lrd,
	output sll_pkg::sll_dreq_t        dreq,
	input  logic [sll_pkg::DATA_W-1:0] drd
);
	import sll_pkg::*;

	typedef enum logic [5:0] {
		S_INIT, S_IDLE, S_START, S_NEW1, S_NEW2, S_NEW3,
		S_CLR1, S_CLR2, S_CLR3, S_CLRW, S_CLRE, S_EMPTY,
		S_LEN, S_DISP, S_TF0, S_TF1, S_TF2, S_WK0, S_WK, S_AFTER, S_INS,
		S_DEL1, S_DEL2, S_DEL3, S_DEL4, S_FIND, S_FSCAN, S_NEXT,
		S_PRIOR0, S_PRIOR1, S_PSCAN, S_PDATA, S_FIN
	} state_t;

	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [IDX_W-1:0]    h_q;
	logic [POS_W-1:0]    pos_q;
	logic [DATA_W-1:0]   v_q;
	logic [CNT_W-1:0]    s_q;
	logic [CNT_W-1:0]    len_q;
	logic [CNT_W-1:0]    steps_q;
	logic [IDX_W-1:0]    i_q;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    k_q;
	logic                init_cmd_q;
	sll_res_t            res_q;
	logic [CNT_W-1:0]    s_inc;
	logic                pos_in_len;
	logic                pos_in_ins;

	assign s_inc      = s_q + CNT_W'(1);
	assign pos_in_len = (pos_q != '0) && (pos_q <= len_q);
	assign pos_in_ins = (pos_q != '0) && ({1'b0, pos_q} <= ({1'b0, len_q} + (CNT_W+1)'(1)));

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

	// memory requests
	always_comb begin
		lreq       = '0;
		dreq       = '0;
		lreq.raddr = h_q;
		dreq.raddr = h_q;
		dreq.wdata = v_q;
		case (state_q)
			S_INIT: begin
				lreq.we    = 1'b1;
				lreq.waddr = k_q;
				lreq.wdata = k_q + IDX_W'(1);
			end
			S_START: lreq.raddr = (cmd_q == CMD_NEW) ? '0 : h_q;
			S_NEW1:  lreq.raddr = lrd;
			S_NEW2: begin
				lreq.we    = 1'b1;
				lreq.waddr = '0;
				lreq.wdata = lrd;
			end
			S_NEW3: begin
				lreq.we    = 1'b1;
				lreq.waddr = i_q;
				lreq.wdata = '0;
			end
			S_CLR1: begin
				lreq.we    = (lrd != '0);
				lreq.waddr = h_q;
				lreq.wdata = '0;
			end
			S_CLR2: lreq.raddr = '0;
			S_CLR3: begin
				lreq.we    = 1'b1;
				lreq.waddr = '0;
				lreq.wdata = i_q;
				lreq.raddr = i_q;
			end
			S_CLRW: lreq.raddr = lrd;
			S_CLRE: begin
				lreq.we    = 1'b1;
				lreq.waddr = j_q;
				lreq.wdata = k_q;
			end
			S_LEN:  lreq.raddr = lrd;
			S_TF0:  lreq.raddr = '0;
			S_TF1:  lreq.raddr = lrd;
			S_TF2: begin
				lreq.we    = 1'b1;
				lreq.waddr = '0;
				lreq.wdata = lrd;
				dreq.we    = 1'b1;
				dreq.waddr = j_q;
			end
			S_WK: begin
				lreq.raddr = lrd;
				dreq.raddr = lrd;
			end
			S_AFTER: begin
				if (cmd_q == CMD_INSERT) begin
					lreq.we    = 1'b1;
					lreq.waddr = j_q;
					lreq.wdata = lrd;
				end
				lreq.raddr = lrd;
				dreq.raddr = lrd;
			end
			S_INS: begin
				lreq.we    = 1'b1;
				lreq.waddr = k_q;
				lreq.wdata = j_q;
			end
			S_DEL1: begin
				lreq.we    = 1'b1;
				lreq.waddr = k_q;
				lreq.wdata = lrd;
			end
			S_DEL2: lreq.raddr = '0;
			S_DEL3: begin
				lreq.we    = 1'b1;
				lreq.waddr = j_q;
				lreq.wdata = lrd;
			end
			S_DEL4: begin
				lreq.we    = 1'b1;
				lreq.waddr = '0;
				lreq.wdata = j_q;
			end
			S_FIND, S_FSCAN, S_PRIOR1: begin
				lreq.raddr = lrd;
				dreq.raddr = lrd;
			end
			S_PRIOR0: lreq.raddr = lrd;
			S_PSCAN: begin
				lreq.raddr = lrd;
				dreq.raddr = (drd == v_q) ? j_q : lrd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			k_q        <= '0;
			init_cmd_q <= 1'b0;
			res_q      <= '0;
			cmd_q      <= '0;
			h_q        <= '0;
			pos_q      <= '0;
			v_q        <= '0;
			s_q        <= '0;
			len_q      <= '0;
			steps_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == LAST_IDX) begin
						if (init_cmd_q) begin
							res_q.ok <= 1'b1;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= cmd;
						h_q        <= list_head;
						pos_q      <= position;
						v_q        <= value;
						s_q        <= '0;
						res_q      <= '0;
						k_q        <= '0;
						init_cmd_q <= 1'b1;
						if (cmd == CMD_INIT) begin
							state_q <= S_INIT;
						end else if (cmd > CMD_DELETE) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					case (cmd_q)
						CMD_NEW:    state_q <= S_NEW1;
						CMD_CLEAR:  state_q <= S_CLR1;
						CMD_EMPTY:  state_q <= S_EMPTY;
						CMD_LOCATE, CMD_NEXT: state_q <= S_FIND;
						CMD_PRIOR:  state_q <= S_PRIOR0;
						default:    state_q <= S_LEN;
					endcase
				end
				S_NEW1: begin
					i_q     <= lrd;
					state_q <= (lrd == '0) ? S_FIN : S_NEW2;
				end
				S_NEW2: state_q <= S_NEW3;
				S_NEW3: begin
					res_q.ok    <= 1'b1;
					res_q.index <= i_q;
					state_q     <= S_FIN;
				end
				S_CLR1: begin
					i_q <= lrd;
					if (lrd == '0) begin
						res_q.ok <= 1'b1;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_CLR2;
					end
				end
				S_CLR2: state_q <= S_CLR3;
				S_CLR3: begin
					k_q     <= lrd;
					j_q     <= i_q;
					s_q     <= CNT_W'(1);
					state_q <= S_CLRW;
				end
				S_CLRW: begin
					if ((lrd != '0) && (s_q < ENTRIES_C)) begin
						j_q <= lrd;
						s_q <= s_inc;
					end else begin
						state_q <= S_CLRE;
					end
				end
				S_CLRE: begin
					res_q.ok <= 1'b1;
					state_q  <= S_FIN;
				end
				S_EMPTY: begin
					res_q.ok <= (lrd == '0);
					state_q  <= S_FIN;
				end
				S_LEN: begin
					if ((lrd == '0) || (s_q == ENTRIES_C)) begin
						len_q   <= s_q;
						state_q <= S_DISP;
					end else begin
						s_q <= s_inc;
					end
				end
				S_DISP: begin
					case (cmd_q)
						CMD_LENGTH: begin
							res_q.ok    <= 1'b1;
							res_q.count <= len_q[IDX_W] ? 8'hFF : len_q[7:0];
							state_q     <= S_FIN;
						end
						CMD_GET: begin
							steps_q <= pos_q;
							state_q <= pos_in_len ? S_WK0 : S_FIN;
						end
						CMD_DELETE: begin
							steps_q <= pos_q - POS_W'(1);
							state_q <= pos_in_len ? S_WK0 : S_FIN;
						end
						CMD_INSERT: begin
							steps_q <= pos_q - POS_W'(1);
							state_q <= pos_in_ins ? S_TF0 : S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_TF0: state_q <= S_TF1;
				S_TF1: begin
					j_q     <= lrd;
					state_q <= (lrd == '0) ? S_FIN : S_TF2;
				end
				S_TF2: state_q <= S_WK0;
				S_WK0: begin
					k_q     <= h_q;
					s_q     <= '0;
					state_q <= (steps_q == '0) ? S_AFTER : S_WK;
				end
				S_WK: begin
					k_q <= lrd;
					s_q <= s_inc;
					if (s_inc == steps_q) begin
						state_q <= S_AFTER;
					end
				end
				S_AFTER: begin
					case (cmd_q)
						CMD_GET: begin
							res_q.ok    <= 1'b1;
							res_q.value <= drd;
							state_q     <= S_FIN;
						end
						CMD_INSERT: state_q <= S_INS;
						default: begin
							j_q     <= lrd;
							state_q <= (lrd == '0) ? S_FIN : S_DEL1;
						end
					endcase
				end
				S_INS: begin
					res_q.ok <= 1'b1;
					state_q  <= S_FIN;
				end
				S_DEL1: begin
					res_q.value <= drd;
					state_q     <= S_DEL2;
				end
				S_DEL2: state_q <= S_DEL3;
				S_DEL3: state_q <= S_DEL4;
				S_DEL4: begin
					res_q.ok <= 1'b1;
					state_q  <= S_FIN;
				end
				S_FIND: begin
					i_q     <= lrd;
					s_q     <= '0;
					state_q <= (lrd == '0) ? S_FIN : S_FSCAN;
				end
				S_FSCAN: begin
					if (drd == v_q) begin
						if (cmd_q == CMD_LOCATE) begin
							res_q.ok    <= 1'b1;
							res_q.index <= i_q;
							state_q     <= S_FIN;
						end else begin
							state_q <= (lrd == '0) ? S_FIN : S_NEXT;
						end
					end else if ((lrd == '0) || (s_inc == ENTRIES_C)) begin
						state_q <= S_FIN;
					end else begin
						i_q <= lrd;
						s_q <= s_inc;
					end
				end
				S_NEXT: begin
					res_q.ok    <= 1'b1;
					res_q.value <= drd;
					state_q     <= S_FIN;
				end
				S_PRIOR0: begin
					j_q     <= lrd;
					state_q <= (lrd == '0) ? S_FIN : S_PRIOR1;
				end
				S_PRIOR1: begin
					i_q     <= lrd;
					s_q     <= CNT_W'(1);
					state_q <= (lrd == '0) ? S_FIN : S_PSCAN;
				end
				S_PSCAN: begin
					if (drd == v_q) begin
						state_q <= S_PDATA;
					end else if (s_q == ENTRIES_C) begin
						state_q <= S_FIN;
					end else begin
						j_q <= i_q;
						i_q <= lrd;
						s_q <= s_inc;
						if (lrd == '0) begin
							state_q <= S_FIN;
						end
					end
				end
				S_PDATA: begin
					res_q.ok    <= 1'b1;
					res_q.value <= drd;
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/static_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Static linked lists with a free chain held in a link RAM and a data RAM.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   cmd, list_head, position, value
//   out      out_valid / out_stall ok, value_out, index_out, count
//
// one item at a time; a list walk reads one node at a time through the
// link RAM read port, and insert and delete walk the list to count it first
// after reset a pass over every entry rebuilds the free chain with in_stall high;
// the re-chain command runs the same pass
// a finished result sits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module static_linked_list_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sll_pkg::CMD_W-1:0]   cmd,
	input  logic [sll_pkg::IDX_W-1:0]   list_head,
	input  logic [sll_pkg::POS_W-1:0]   position,
	input  logic signed [sll_pkg::DATA_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic signed [sll_pkg::DATA_W-1:0] value_out,
	output logic [sll_pkg::IDX_W-1:0]   index_out,
	output logic [7:0]                  count
);
	import sll_pkg::*;

	sll_lreq_t         lreq;
	sll_dreq_t         dreq;
	logic [IDX_W-1:0]  lrd;
	logic [DATA_W-1:0] drd;
	logic              res_valid;
	logic              res_take;
	sll_res_t          res;
	logic              out_vld_q;
	sll_res_t          out_q;

	sll_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_link_ram (
		.clk   (clk),
		.we    (lreq.we),
		.waddr (lreq.waddr),
		.wdata (lreq.wdata),
		.raddr (lreq.raddr),
		.rdata (lrd)
	);

	sll_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
		.clk   (clk),
		.we    (dreq.we),
		.waddr (dreq.waddr),
		.wdata (dreq.wdata),
		.raddr (dreq.raddr),
		.rdata (drd)
	);

	sll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.list_head (list_head),
		.position  (position),
		.value     (value),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.lreq      (lreq),
		.lrd       (lrd),
		.dreq      (dreq),
		.drd       (drd)
	);

	assign res_take = !out_vld_q || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (res_valid && res_take) begin
				out_vld_q <= 1'b1;
				out_q     <= res;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign ok        = out_q.ok;
	assign value_out = out_q.value;
	assign index_out = out_q.index;
	assign count     = out_q.count;

endmodule

### sim/static_linked_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine_test
// Drives list commands through the valid/stall input channel and checks every
// result against a local model of the node array and free chain. Directed
// corner items come first, then random traffic over a handful of live lists,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module static_linked_list_engine_test;
	import sll_pkg::*;

	class chain_scoreboard;
		int                link [ENTRIES];
		logic [DATA_W-1:0] data [ENTRIES];
		bit                written [ENTRIES];
		sll_res_t          expected_q [$];
		logic [IDX_W-1:0]  heads [$];
		int                mismatches;

		function void rechain();
			for (int k = 0; k < ENTRIES; k++)
				link[k] = (k + 1 < ENTRIES) ? k + 1 : 0;
		endfunction

		function new();
			rechain();
			mismatches = 0;
			foreach (written[k])
				written[k] = 1'b0;
		endfunction

		function int take_free();
			int i;
			i = link[0];
			if (i != 0)
				link[0] = link[i];
			return i;
		endfunction

		function int chain_len(int h);
			int i, n;
			i = link[h];
			n = 0;
			while (i != 0 && n < ENTRIES) begin
				i = link[i];
				n++;
			end
			return n;
		endfunction

		function int walk(int h, int steps);
			int k;
			k = h;
			for (int s = 0; s < steps; s++)
				k = link[k];
			return k;
		endfunction

		function int find(int h, logic [DATA_W-1:0] v);
			int i, s;
			i = link[h];
			s = 0;
			while (i != 0 && s < ENTRIES) begin
				if (data[i] == v)
					return i;
				i = link[i];
				s++;
			end
			return 0;
		endfunction

		// every node reachable from the head holds written data
		function bit reads_safe(int h);
			int i, s;
			i = link[h];
			s = 0;
			while (i != 0 && s <= ENTRIES) begin
				if (!written[i])
					return 0;
				i = link[i];
				s++;
			end
			return 1;
		endfunction

		function void note(logic [CMD_W-1:0] c, logic [IDX_W-1:0] hd,
				logic [POS_W-1:0] pos, logic [DATA_W-1:0] v);
			sll_res_t r;
			int h, p, i, j, k, len, s;
			r = '0;
			h = int'(hd);
			p = int'(pos);
			case (c)
				CMD_INIT: begin
					rechain();
					heads.delete();
					r.ok = 1'b1;
				end
				CMD_NEW: begin
					i = take_free();
					if (i != 0) begin
						link[i] = 0;
						r.ok = 1'b1;
						r.index = IDX_W'(i);
						heads.push_back(IDX_W'(i));
					end
				end
				CMD_CLEAR: begin
					i = link[h];
					if (i != 0) begin
						link[h] = 0;
						k = link[0];
						link[0] = i;
						j = i;
						s = 0;
						while (i != 0 && s < ENTRIES) begin
							j = i;
							i = link[i];
							s++;
						end
						link[j] = k;
					end
					r.ok = 1'b1;
				end
				CMD_EMPTY: r.ok = (link[h] == 0);
				CMD_LENGTH: begin
					len = chain_len(h);
					r.ok = 1'b1;
					r.count = 8'(len > 255 ? 255 : len);
				end
				CMD_GET: begin
					len = chain_len(h);
					if (p >= 1 && p <= len) begin
						r.value = data[walk(h, p)];
						r.ok = 1'b1;
					end
				end
				CMD_LOCATE: begin
					i = find(h, v);
					r.ok = (i != 0);
					r.index = IDX_W'(i);
				end
				CMD_PRIOR: begin
					i = link[h];
					if (i != 0) begin
						s = 0;
						do begin
							j = i;
							i = link[i];
							s++;
						end while (i != 0 && data[i] != v && s < ENTRIES);
						if (i != 0 && data[i] == v) begin
							r.value = data[j];
							r.ok = 1'b1;
						end
					end
				end
				CMD_NEXT: begin
					i = find(h, v);
					if (i != 0) begin
						i = link[i];
						if (i != 0) begin
							r.value = data[i];
							r.ok = 1'b1;
						end
					end
				end
				CMD_INSERT: begin
					len = chain_len(h);
					if (p >= 1 && p <= len + 1) begin
						j = take_free();
						if (j != 0) begin
							data[j] = v;
							written[j] = 1'b1;
							k = walk(h, p - 1);
							link[j] = link[k];
							link[k] = j;
							r.ok = 1'b1;
						end
					end
				end
				CMD_DELETE: begin
					len = chain_len(h);
					if (p >= 1 && p <= len) begin
						k = walk(h, p - 1);
						j = link[k];
						if (j != 0) begin
							link[k] = link[j];
							r.value = data[j];
							link[j] = link[0];
							link[0] = j;
							r.ok = 1'b1;
						end
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check(logic o, logic [DATA_W-1:0] vo, logic [IDX_W-1:0] io,
				logic [7:0] cnt);
			sll_res_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result ok=%0b value=%h index=%0d count=%0d",
						o, vo, io, cnt);
				return;
			end
			e = expected_q.pop_front();
			if (o !== e.ok || vo !== e.value || io !== e.index || cnt !== e.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp ok=%0b value=%h index=%0d count=%0d, got ok=%0b value=%h index=%0d count=%0d",
						e.ok, e.value, e.index, e.count, o, vo, io, cnt);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd = '0;
	logic [IDX_W-1:0]  list_head = '0;
	logic [POS_W-1:0]  position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              ok;
	logic signed [DATA_W-1:0] value_out;
	logic [IDX_W-1:0]  index_out;
	logic [7:0]        count;

	chain_scoreboard sb = new();
	bit quiet = 1'b0;

	static_linked_list_engine i_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check(ok, value_out, index_out, count);
		out_stall <= !quiet && ($urandom_range(0, 99) < 8);
	end

	task automatic send(logic [CMD_W-1:0] c, logic [IDX_W-1:0] h,
			logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
		if (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		list_head <= h;
		position  <= p;
		value     <= v;
		do @(posedge clk); while (in_stall);
		sb.note(c, h, p, v);
	endtask

	task automatic random_item();
		logic [CMD_W-1:0]  c;
		logic [IDX_W-1:0]  h;
		logic [POS_W-1:0]  p;
		logic [DATA_W-1:0] v;
		int r, len;
		if (sb.heads.size() > 0 && $urandom_range(0, 99) < 85)
			h = sb.heads[$urandom_range(0, sb.heads.size() - 1)];
		else
			h = IDX_W'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 2) c = CMD_INIT;
		else if (r < 8) c = (sb.heads.size() > 12) ? CMD_INSERT : CMD_NEW;
		else if (r < 12) c = CMD_CLEAR;
		else if (r < 16) c = CMD_EMPTY;
		else if (r < 22) c = CMD_LENGTH;
		else if (r < 32) c = CMD_GET;
		else if (r < 40) c = CMD_LOCATE;
		else if (r < 47) c = CMD_PRIOR;
		else if (r < 54) c = CMD_NEXT;
		else if (r < 82) c = CMD_INSERT;
		else if (r < 97) c = CMD_DELETE;
		else c = CMD_W'($urandom_range(11, 15));
		if ((c == CMD_GET || c == CMD_LOCATE || c == CMD_PRIOR || c == CMD_NEXT ||
				c == CMD_DELETE) && !sb.reads_safe(int'(h)))
			c = CMD_LENGTH;
		len = sb.chain_len(int'(h));
		if ($urandom_range(0, 99) < 5)
			p = POS_W'($urandom_range(0, 256));
		else
			p = POS_W'($urandom_range(0, len + 2));
		r = $urandom_range(0, 99);
		if (r < 50 && len > 0 && sb.reads_safe(int'(h)))
			v = sb.data[sb.walk(int'(h), $urandom_range(1, len))];
		else if (r < 60)
			v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
		else
			v = $urandom;
		send(c, h, p, v);
	endtask

	initial begin
		logic [IDX_W-1:0] h;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_NEW, '0, '0, '0);
		h = sb.heads[$];
		send(CMD_CLEAR, h, '0, '0);
		send(CMD_EMPTY, h, '0, '0);
		send(CMD_PRIOR, h, '0, '0);
		send(CMD_GET, h, 9'd1, '0);
		send(CMD_INSERT, h, '0, 32'd1);
		send(CMD_INSERT, h, 9'd1, 32'h7fff_ffff);
		send(CMD_INSERT, h, 9'd2, 32'h8000_0000);
		send(CMD_INSERT, h, 9'd1, '0);
		send(CMD_INSERT, h, 9'd4, 32'hffff_ffff);
		send(CMD_INSERT, h, 9'd6, 32'd7);
		send(CMD_LENGTH, h, '0, '0);
		send(CMD_GET, h, 9'd4, '0);
		send(CMD_GET, h, 9'd5, '0);
		send(CMD_LOCATE, h, '0, 32'h8000_0000);
		send(CMD_LOCATE, h, '0, 32'd5);
		send(CMD_PRIOR, h, '0, '0);
		send(CMD_PRIOR, h, '0, 32'hffff_ffff);
		send(CMD_NEXT, h, '0, 32'hffff_ffff);
		send(CMD_NEXT, h, '0, '0);
		send(CMD_DELETE, h, 9'd2, '0);
		send(CMD_DELETE, h, '0, '0);
		send(CMD_EMPTY, h, '0, '0);
		send(CMD_CLEAR, h, '0, '0);
		send(4'd11, 8'hff, 9'd256, 32'hffff_ffff);
		send(4'd15, 8'hff, 9'd511, '0);

		for (int n = 0; n < 1150; n++) begin
			quiet = (n >= 300 && n < 500);
			if (n == 600) begin
				in_valid <= 1'b0;
				wait (sb.expected_q.size() == 0);
				@(posedge clk);
			end
			random_item();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;
		wait (sb.expected_q.size() == 0);
		repeat (600) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
